// ----- design/dcmi_pkg.sv -----
// Shared types, widths and helpers for the DC motor model integrator.
// No dependencies; every other file of the block imports this package.
package dcmi_pkg;

  localparam int STATE_WIDTH = 48;
  localparam int COEF_WIDTH  = 32;
  localparam int IO_WIDTH    = 48;
  localparam int CONST_WIDTH = 32;

  // Binary points: coefficients are Q.20, step constants and states Q.32.
  localparam int COEF_FRAC  = 20;
  localparam int CONST_FRAC = 32;

  localparam int MUL_WIDTH   = (COEF_WIDTH > CONST_WIDTH) ? COEF_WIDTH : CONST_WIDTH;
  localparam int CFG_WIDTH   = MUL_WIDTH;
  localparam int MCAND_WIDTH = ((STATE_WIDTH > IO_WIDTH) ? STATE_WIDTH : IO_WIDTH) + 1;
  localparam int ACC_WIDTH   = MCAND_WIDTH + MUL_WIDTH + 3;
  localparam int CNT_WIDTH   = $clog2(MUL_WIDTH);
  localparam int IO_EXT_WIDTH = STATE_WIDTH + IO_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  localparam logic signed [ACC_WIDTH-1:0] ROUND_COEF  = ACC_WIDTH'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_WIDTH-1:0] ROUND_CONST = ACC_WIDTH'(1) << (CONST_FRAC - 1);

  localparam logic [COEF_WIDTH-1:0]  DAMPING_RESET   = COEF_WIDTH'(3670016);
  localparam logic [COEF_WIDTH-1:0]  STIFFNESS_RESET = COEF_WIDTH'(3565158);
  localparam logic [COEF_WIDTH-1:0]  SHAFT_GAIN_RESET   = COEF_WIDTH'(209715);
  localparam logic [COEF_WIDTH-1:0]  CURRENT_GAIN_RESET = COEF_WIDTH'(314573);
  localparam logic [COEF_WIDTH-1:0]  RATE_GAIN_RESET    = COEF_WIDTH'(209715);
  localparam logic [CONST_WIDTH-1:0] STEP_H_RESET       = CONST_WIDTH'(4294967);
  localparam logic [CONST_WIDTH-1:0] HALF_STEP_SQ_RESET = CONST_WIDTH'(2147);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_DAMPING,
    CFG_STIFFNESS,
    CFG_SHAFT_GAIN,
    CFG_CURRENT_GAIN,
    CFG_RATE_GAIN,
    CFG_STEP_H,
    CFG_HALF_STEP_SQ
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y2_DAMP,
    ST_Y2_STIFF,
    ST_Y2_GAIN,
    ST_Y2_RATE,
    ST_VAL_SLOPE,
    ST_VAL_ACCEL,
    ST_SLOPE_ACCEL,
    ST_SLOPE_WB,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    PRE_ROUND,
    PRE_VALUE,
    PRE_SLOPE
  } pre_sel_t;

  typedef enum logic [2:0] {
    MC_SLOPE,
    MC_VALUE,
    MC_DRIVE,
    MC_DRIVE_RATE,
    MC_Y2
  } mcand_sel_t;

  typedef enum logic [2:0] {
    ML_DAMPING,
    ML_STIFFNESS,
    ML_GAIN,
    ML_RATE_GAIN,
    ML_STEP,
    ML_HALF_SQ
  } mult_sel_t;

  // Command to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic preload;
    logic mult_signed;
  } mac_cmd_t;

  // Sequencer outputs toward the datapath.
  typedef struct packed {
    mac_cmd_t   mac;
    pre_sel_t   pre_sel;
    mcand_sel_t mcand_sel;
    mult_sel_t  mult_sel;
    logic       negate;
    logic       ch;
    logic       y2_load;
    logic       value_load;
    logic       slope_load;
    logic       out_load;
    logic       in_ready;
  } dcmi_ctrl_t;

  // Clamp an accumulator value to the signed state range.
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [ACC_WIDTH-1:0] x);
    logic signed [STATE_WIDTH-1:0] r;
    if (x > ACC_WIDTH'(STATE_MAX)) begin
      r = STATE_MAX;
    end else if (x < ACC_WIDTH'(STATE_MIN)) begin
      r = STATE_MIN;
    end else begin
      r = STATE_WIDTH'(x);
    end
    return r;
  endfunction

  // Sign-extend or truncate a state to the output field width.
  function automatic logic [IO_WIDTH-1:0] to_io(input logic signed [STATE_WIDTH-1:0] v);
    logic signed [IO_EXT_WIDTH-1:0] w;
    w = IO_EXT_WIDTH'(v);
    return w[IO_WIDTH-1:0];
  endfunction

endpackage

// ----- design/dcmi_if.sv -----
// Valid/ready channel interfaces for the integrator's input and result items.
// Depends on dcmi_pkg for the field widths.
interface dcmi_sample_if;
  import dcmi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [IO_WIDTH-1:0] drive;
  logic signed [IO_WIDTH-1:0] drive_rate;

  modport source (output valid, output drive, output drive_rate, input ready);
  modport sink   (input valid, input drive, input drive_rate, output ready);
endinterface

interface dcmi_result_if;
  import dcmi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [IO_WIDTH-1:0] shaft_out;
  logic signed [IO_WIDTH-1:0] current_out;

  modport source (output valid, output shaft_out, output current_out, input ready);
  modport sink   (input valid, input shaft_out, input current_out, output ready);
endinterface

// ----- design/dcmi_mac.sv -----
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
// Depends on dcmi_pkg for widths and the command struct.
module dcmi_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dcmi_pkg::mac_cmd_t                    cmd,
  input  logic signed [dcmi_pkg::ACC_WIDTH-1:0]   preload_value,
  input  logic signed [dcmi_pkg::MCAND_WIDTH-1:0] mcand,
  input  logic [dcmi_pkg::MUL_WIDTH-1:0]          mult,
  output logic signed [dcmi_pkg::ACC_WIDTH-1:0]   acc,
  output logic                                  done
);
  import dcmi_pkg::*;

  logic                        busy;
  logic [CNT_WIDTH-1:0]        count;
  logic [MUL_WIDTH-1:0]        mult_sh;
  logic signed [ACC_WIDTH-1:0] mcand_sh;
  logic                        msigned;
  logic                        last;
  logic signed [ACC_WIDTH-1:0] addend;

  assign last   = (count == CNT_WIDTH'(MUL_WIDTH - 1));
  assign addend = mult_sh[0] ? mcand_sh : '0;
  assign done   = busy && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + CNT_WIDTH'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // The top multiplier bit carries negative weight for a signed multiplier.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mult_sh  <= mult;
      mcand_sh <= ACC_WIDTH'(mcand);
      msigned  <= cmd.mult_signed;
      if (cmd.preload) begin
        acc <= preload_value;
      end
    end else if (busy) begin
      mult_sh  <= mult_sh >> 1;
      mcand_sh <= mcand_sh <<< 1;
      if (last && msigned) begin
        acc <= acc - addend;
      end else begin
        acc <= acc + addend;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("multiply started while the unit was busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) cmd.start |=> busy)
    else $error("multiply did not start");
  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("unit still busy after its last bit");

endmodule

// ----- design/dcmi_seq.sv -----
// Sequencer that steps both channels through their products and write-backs.
// Depends on dcmi_pkg for the state enum and the control struct.
module dcmi_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                mac_done,
  input  logic                out_free,
  output dcmi_pkg::dcmi_ctrl_t ctrl
);
  import dcmi_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  logic       ch;
  logic       first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first <= 1'b0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      first <= (state_next != state);
      if (state == ST_IDLE) begin
        ch <= 1'b0;
      end else if (state == ST_SLOPE_WB) begin
        ch <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_Y2_DAMP;
      end
      ST_Y2_DAMP: begin
        if (mac_done) state_next = ST_Y2_STIFF;
      end
      ST_Y2_STIFF: begin
        if (mac_done) state_next = ST_Y2_GAIN;
      end
      ST_Y2_GAIN: begin
        if (mac_done) state_next = ch ? ST_Y2_RATE : ST_VAL_SLOPE;
      end
      ST_Y2_RATE: begin
        if (mac_done) state_next = ST_VAL_SLOPE;
      end
      ST_VAL_SLOPE: begin
        if (mac_done) state_next = ST_VAL_ACCEL;
      end
      ST_VAL_ACCEL: begin
        if (mac_done) state_next = ST_SLOPE_ACCEL;
      end
      ST_SLOPE_ACCEL: begin
        if (mac_done) state_next = ST_SLOPE_WB;
      end
      ST_SLOPE_WB: begin
        state_next = ch ? ST_OUT : ST_Y2_DAMP;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.mac.start       = 1'b0;
    ctrl.mac.preload     = 1'b0;
    ctrl.mac.mult_signed = 1'b1;
    ctrl.pre_sel         = PRE_ROUND;
    ctrl.mcand_sel       = MC_SLOPE;
    ctrl.mult_sel        = ML_DAMPING;
    ctrl.negate          = 1'b0;
    ctrl.ch              = ch;
    ctrl.y2_load         = 1'b0;
    ctrl.value_load      = 1'b0;
    ctrl.slope_load      = 1'b0;
    ctrl.out_load        = 1'b0;
    ctrl.in_ready        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
      end
      ST_Y2_DAMP: begin
        ctrl.mac.start   = first;
        ctrl.mac.preload = 1'b1;
        ctrl.pre_sel     = PRE_ROUND;
        ctrl.mcand_sel   = MC_SLOPE;
        ctrl.negate      = 1'b1;
        ctrl.mult_sel    = ML_DAMPING;
      end
      ST_Y2_STIFF: begin
        ctrl.mac.start = first;
        ctrl.mcand_sel = MC_VALUE;
        ctrl.negate    = 1'b1;
        ctrl.mult_sel  = ML_STIFFNESS;
      end
      ST_Y2_GAIN: begin
        ctrl.mac.start = first;
        ctrl.mcand_sel = MC_DRIVE;
        ctrl.mult_sel  = ML_GAIN;
      end
      ST_Y2_RATE: begin
        ctrl.mac.start = first;
        ctrl.mcand_sel = MC_DRIVE_RATE;
        ctrl.mult_sel  = ML_RATE_GAIN;
      end
      ST_VAL_SLOPE: begin
        ctrl.mac.start       = first;
        ctrl.mac.preload     = 1'b1;
        ctrl.mac.mult_signed = 1'b0;
        ctrl.pre_sel         = PRE_VALUE;
        ctrl.mcand_sel       = MC_SLOPE;
        ctrl.mult_sel        = ML_STEP;
        ctrl.y2_load         = first;
      end
      ST_VAL_ACCEL: begin
        ctrl.mac.start       = first;
        ctrl.mac.mult_signed = 1'b0;
        ctrl.mcand_sel       = MC_Y2;
        ctrl.mult_sel        = ML_HALF_SQ;
      end
      ST_SLOPE_ACCEL: begin
        ctrl.mac.start       = first;
        ctrl.mac.preload     = 1'b1;
        ctrl.mac.mult_signed = 1'b0;
        ctrl.pre_sel         = PRE_SLOPE;
        ctrl.mcand_sel       = MC_Y2;
        ctrl.mult_sel        = ML_STEP;
        ctrl.value_load      = first;
      end
      ST_SLOPE_WB: begin
        ctrl.slope_load = 1'b1;
      end
      ST_OUT: begin
        ctrl.out_load = out_free;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

  a_done_in_op: assert property (@(posedge clk) disable iff (rst)
      mac_done |-> (state != ST_IDLE && state != ST_SLOPE_WB && state != ST_OUT))
    else $error("multiply finished outside a product step");
  a_fire_begins: assert property (@(posedge clk) disable iff (rst)
      in_fire |=> (state == ST_Y2_DAMP && ch == 1'b0))
    else $error("accepted item did not start on the shaft channel");
  a_channel_turn: assert property (@(posedge clk) disable iff (rst)
      (state == ST_SLOPE_WB && !ch) |=> (state == ST_Y2_DAMP && ch))
    else $error("shaft channel did not hand over to the current channel");

endmodule

// ----- design/dc_motor_model_integrator.sv -----
// Top level of the DC motor model integrator: configuration, state and datapath.
// Depends on dcmi_pkg, dcmi_if, dcmi_mac and dcmi_seq.

// Each accepted item advances a two-channel DC motor model by one time step
// with a second-order Taylor update. For the shaft channel and then the
// current channel, the block forms the second derivative
// y'' = -a1*y' - a0*y + b0*u (+ b1*u' on the current channel), rounds it to
// Q15.32 and saturates it, then updates the value with h*y' + (h*h/2)*y''
// using the slope from before the step, and finally updates the slope with
// h*y''. All rounding is half up, and every state saturates to the signed
// 48-bit range instead of wrapping. The result item carries the new shaft
// and current values. All products go through one shared bit-serial
// multiply-accumulate unit that consumes one multiplier bit per cycle
// once a product has been launched. The shaft channel needs 6 products
// and the current channel 7, plus a slope write-back per channel. The
// input side accepts only while the block is idle; the result sits in its
// own output register, so the next item may be accepted while the previous
// result still waits to be taken. Reset clears the model state to zero and
// loads the default coefficients. Configuration writes should be made only
// while no item is in flight; an index past the last register is ignored.
module dc_motor_model_integrator (
  input  logic                                   clk,
  input  logic                                   rst,
  dcmi_sample_if.sink                            sample,
  dcmi_result_if.source                          result,
  input  logic                                   cfg_write,
  input  logic [dcmi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [dcmi_pkg::CFG_WIDTH-1:0]         cfg_data
);
  import dcmi_pkg::*;

  // Configuration registers.
  logic signed [COEF_WIDTH-1:0] damping_coef;
  logic signed [COEF_WIDTH-1:0] stiffness_coef;
  logic signed [COEF_WIDTH-1:0] shaft_gain;
  logic signed [COEF_WIDTH-1:0] current_gain;
  logic signed [COEF_WIDTH-1:0] current_rate_gain;
  logic [CONST_WIDTH-1:0]       step_h;
  logic [CONST_WIDTH-1:0]       half_step_sq;

  // Model state; entry 0 is the shaft channel, entry 1 the current channel.
  logic signed [STATE_WIDTH-1:0] value [2];
  logic signed [STATE_WIDTH-1:0] slope [2];
  logic signed [STATE_WIDTH-1:0] accel;

  logic signed [IO_WIDTH-1:0] drive;
  logic signed [IO_WIDTH-1:0] drive_rate;

  logic                       out_valid;
  logic signed [IO_WIDTH-1:0] out_shaft;
  logic signed [IO_WIDTH-1:0] out_current;

  dcmi_ctrl_t ctrl;
  logic       in_fire;
  logic       out_free;
  logic       mac_done;

  logic signed [ACC_WIDTH-1:0]   acc;
  logic signed [ACC_WIDTH-1:0]   preload_value;
  logic signed [MCAND_WIDTH-1:0] mcand_raw;
  logic signed [MCAND_WIDTH-1:0] mcand;
  logic [MUL_WIDTH-1:0]          mult;

  // No item is taken while reset is held, since the sequencer would drop it.
  assign sample.ready = ctrl.in_ready && !rst;
  assign in_fire      = sample.valid && ctrl.in_ready && !rst;
  assign out_free     = !out_valid || result.ready;

  assign result.valid       = out_valid;
  assign result.shaft_out   = out_shaft;
  assign result.current_out = out_current;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_coef      <= DAMPING_RESET;
      stiffness_coef    <= STIFFNESS_RESET;
      shaft_gain        <= SHAFT_GAIN_RESET;
      current_gain      <= CURRENT_GAIN_RESET;
      current_rate_gain <= RATE_GAIN_RESET;
      step_h            <= STEP_H_RESET;
      half_step_sq      <= HALF_STEP_SQ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DAMPING:      damping_coef      <= cfg_data[COEF_WIDTH-1:0];
        CFG_STIFFNESS:    stiffness_coef    <= cfg_data[COEF_WIDTH-1:0];
        CFG_SHAFT_GAIN:   shaft_gain        <= cfg_data[COEF_WIDTH-1:0];
        CFG_CURRENT_GAIN: current_gain      <= cfg_data[COEF_WIDTH-1:0];
        CFG_RATE_GAIN:    current_rate_gain <= cfg_data[COEF_WIDTH-1:0];
        CFG_STEP_H:       step_h            <= cfg_data[CONST_WIDTH-1:0];
        CFG_HALF_STEP_SQ: half_step_sq      <= cfg_data[CONST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Latch the item so the source may move on while the step runs.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive      <= sample.drive;
      drive_rate <= sample.drive_rate;
    end
  end

  // Write-backs read the accumulator in the cycle after the last product of
  // a group, before the next launch overwrites it. The accumulator already
  // holds the rounding bias and the old state shifted to the product's
  // binary point, so one arithmetic shift finishes the rounding.
  always_ff @(posedge clk) begin
    if (rst) begin
      value[0] <= '0;
      value[1] <= '0;
      slope[0] <= '0;
      slope[1] <= '0;
    end else begin
      if (ctrl.value_load) begin
        value[ctrl.ch] <= sat_state(acc >>> CONST_FRAC);
      end
      if (ctrl.slope_load) begin
        slope[ctrl.ch] <= sat_state(acc >>> CONST_FRAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.y2_load) begin
      accel <= sat_state(acc >>> COEF_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_shaft   <= to_io(value[0]);
      out_current <= to_io(value[1]);
    end
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    case (ctrl.mcand_sel)
      MC_SLOPE:      mcand_raw = MCAND_WIDTH'(slope[ctrl.ch]);
      MC_VALUE:      mcand_raw = MCAND_WIDTH'(value[ctrl.ch]);
      MC_DRIVE:      mcand_raw = MCAND_WIDTH'(drive);
      MC_DRIVE_RATE: mcand_raw = MCAND_WIDTH'(drive_rate);
      MC_Y2:         mcand_raw = MCAND_WIDTH'(accel);
      default:       mcand_raw = '0;
    endcase
    mcand = ctrl.negate ? -mcand_raw : mcand_raw;
  end

  // Coefficients are sign-extended; the step constants are zero-extended and
  // run through the unit as unsigned multipliers.
  always_comb begin
    case (ctrl.mult_sel)
      ML_DAMPING:   mult = MUL_WIDTH'(damping_coef);
      ML_STIFFNESS: mult = MUL_WIDTH'(stiffness_coef);
      ML_GAIN:      mult = ctrl.ch ? MUL_WIDTH'(current_gain) : MUL_WIDTH'(shaft_gain);
      ML_RATE_GAIN: mult = MUL_WIDTH'(current_rate_gain);
      ML_STEP:      mult = MUL_WIDTH'(step_h);
      ML_HALF_SQ:   mult = MUL_WIDTH'(half_step_sq);
      default:      mult = '0;
    endcase
  end

  always_comb begin
    case (ctrl.pre_sel)
      PRE_ROUND: preload_value = ROUND_COEF;
      PRE_VALUE: preload_value = (ACC_WIDTH'(value[ctrl.ch]) <<< CONST_FRAC) + ROUND_CONST;
      PRE_SLOPE: preload_value = (ACC_WIDTH'(slope[ctrl.ch]) <<< CONST_FRAC) + ROUND_CONST;
      default:   preload_value = '0;
    endcase
  end

  dcmi_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl.mac),
    .preload_value (preload_value),
    .mcand         (mcand),
    .mult          (mult),
    .acc           (acc),
    .done          (mac_done)
  );

  dcmi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .mac_done (mac_done),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the DC motor model integrator: it drives time-step
// items, predicts both channel values in fixed point and checks every result item.
// Depends on dcmi_pkg, the dcmi_if channel interfaces and the integrator RTL.
module testbench;
  import dcmi_pkg::*;

  // Wide enough to hold every exact product and sum of the Taylor step.
  typedef logic signed [127:0] exact_t;

  typedef struct {
    logic signed [IO_WIDTH-1:0] drive;
    logic signed [IO_WIDTH-1:0] drive_rate;
  } step_item_t;

  typedef struct {
    logic signed [IO_WIDTH-1:0] shaft;
    logic signed [IO_WIDTH-1:0] current;
  } motor_result_t;

  typedef enum {RX_OPEN, RX_SHUT, RX_CHOPPY} rx_mode_t;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          NOISY_LIMIT = 10;

  // The register index just past the last real register; writes to it are ignored.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = '1;

  localparam logic signed [IO_WIDTH-1:0] DRIVE_MAX = {1'b0, {(IO_WIDTH-1){1'b1}}};
  localparam logic signed [IO_WIDTH-1:0] DRIVE_MIN = {1'b1, {(IO_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  localparam exact_t SAT_HI = (128'sd1 <<< (STATE_WIDTH - 1)) - 128'sd1;
  localparam exact_t SAT_LO = -(128'sd1 <<< (STATE_WIDTH - 1));

  // Nominal coefficient values after reset (a1 = 3.5, a0 = 3.4, gains 0.2/0.3/0.2,
  // h = 0.001 and h*h/2 in Q0.32).
  localparam logic signed [COEF_WIDTH-1:0] NOM_DAMPING   = 32'sd3670016;
  localparam logic signed [COEF_WIDTH-1:0] NOM_STIFFNESS = 32'sd3565158;
  localparam logic signed [COEF_WIDTH-1:0] NOM_SHAFT     = 32'sd209715;
  localparam logic signed [COEF_WIDTH-1:0] NOM_CURRENT   = 32'sd314573;
  localparam logic signed [COEF_WIDTH-1:0] NOM_RATE      = 32'sd209715;
  localparam logic [CONST_WIDTH-1:0]       NOM_STEP      = 32'd4294967;
  localparam logic [CONST_WIDTH-1:0]       NOM_HALF_SQ   = 32'd2147;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;

  dcmi_sample_if step_ch ();
  dcmi_result_if result_ch ();

  dc_motor_model_integrator dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (step_ch),
    .result   (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Items waiting to be offered to the block, and the values each accepted
  // item should produce, oldest first.
  step_item_t    pending_steps[$];
  motor_result_t expected_results[$];

  // The testbench's own copy of the coefficients and of the motor state.
  logic signed [COEF_WIDTH-1:0]  k_damping, k_stiffness, k_shaft_gain;
  logic signed [COEF_WIDTH-1:0]  k_current_gain, k_rate_gain;
  logic [CONST_WIDTH-1:0]        k_step, k_half_sq;
  logic signed [STATE_WIDTH-1:0] shaft_y, shaft_dy, curr_y, curr_dy;

  int          fault_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point prediction of one Taylor step.
  // ---------------------------------------------------------------------------

  // Round half up, then shift right arithmetically.
  function automatic exact_t round_shift(input exact_t x, input int s);
    return (x + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Clamp to the signed state range instead of wrapping.
  function automatic logic signed [STATE_WIDTH-1:0] clamp_state(input exact_t x);
    exact_t r;
    if (x > SAT_HI) begin
      r = SAT_HI;
    end else if (x < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = x;
    end
    return r[STATE_WIDTH-1:0];
  endfunction

  // Advances one channel. The second derivative is formed from the old state,
  // and the value update uses the slope from before the step.
  function automatic void step_channel(
      inout logic signed [STATE_WIDTH-1:0] y,
      inout logic signed [STATE_WIDTH-1:0] dy,
      input logic signed [COEF_WIDTH-1:0]  gain,
      input logic signed [COEF_WIDTH-1:0]  rate_gain,
      input logic signed [IO_WIDTH-1:0]    u,
      input logic signed [IO_WIDTH-1:0]    ur);
    exact_t a1, a0, b0, b1, yw, dyw, uw, urw, hw, hhw, acc, y2w;
    logic signed [STATE_WIDTH-1:0] y2, new_dy, new_y;
    a1  = k_damping;
    a0  = k_stiffness;
    b0  = gain;
    b1  = rate_gain;
    yw  = y;
    dyw = dy;
    uw  = u;
    urw = ur;
    hw  = k_step;       // unsigned, so zero-extended
    hhw = k_half_sq;
    acc = -(a1 * dyw) - (a0 * yw) + (b0 * uw) + (b1 * urw);
    y2  = clamp_state(round_shift(acc, COEF_FRAC));
    y2w = y2;
    new_dy = clamp_state(round_shift(hw * y2w, CONST_FRAC) + dyw);
    new_y  = clamp_state(round_shift(hw * dyw + hhw * y2w, CONST_FRAC) + yw);
    dy = new_dy;
    y  = new_y;
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices for fields and registers.
  // ---------------------------------------------------------------------------

  // Mostly physically sized drives, with full-range values and corners mixed in
  // so that every bit of both fields toggles and saturation is reached.
  function automatic logic signed [IO_WIDTH-1:0] pick_drive();
    logic [63:0] r;
    logic signed [IO_WIDTH-1:0] v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: v = $signed(r[37:0]);
      3:       v = $signed(r[20:0]);
      4, 5:    v = r[IO_WIDTH-1:0];
      default: begin
        case ($urandom_range(0, 4))
          0:       v = DRIVE_MAX;
          1:       v = DRIVE_MIN;
          2:       v = '0;
          3:       v = 48'sd1;
          default: v = -48'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] pick_coef(
      input logic signed [COEF_WIDTH-1:0] nominal);
    logic [31:0] r;
    logic signed [COEF_WIDTH-1:0] v;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1: v = nominal + $signed({16'd0, r[15:0]}) - 32'sd32768;
      2:    v = r;
      3:    v = $signed(r[23:0]);
      4:    v = nominal <<< $urandom_range(0, 8);
      default: begin
        case ($urandom_range(0, 2))
          0:       v = COEF_MAX;
          1:       v = COEF_MIN;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // Step constants are taken as given, so h and h*h/2 need not agree.
  function automatic logic [CONST_WIDTH-1:0] pick_step(input logic [CONST_WIDTH-1:0] nominal);
    logic [CONST_WIDTH-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = nominal + $urandom_range(0, nominal);
      2:    v = $urandom;
      3:    v = $urandom_range(0, 1) ? '1 : '0;
      default: v = $urandom_range(0, 32'h0100_0000);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: register writes happen only while the block is idle.
  // ---------------------------------------------------------------------------

  task automatic write_setting(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [CFG_WIDTH-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DAMPING:      k_damping      = data;
      CFG_STIFFNESS:    k_stiffness    = data;
      CFG_SHAFT_GAIN:   k_shaft_gain   = data;
      CFG_CURRENT_GAIN: k_current_gain = data;
      CFG_RATE_GAIN:    k_rate_gain    = data;
      CFG_STEP_H:       k_step         = data;
      CFG_HALF_STEP_SQ: k_half_sq      = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic signed [COEF_WIDTH-1:0] damping,
                           input logic signed [COEF_WIDTH-1:0] stiffness,
                           input logic signed [COEF_WIDTH-1:0] shaft_gain,
                           input logic signed [COEF_WIDTH-1:0] current_gain,
                           input logic signed [COEF_WIDTH-1:0] rate_gain,
                           input logic [CONST_WIDTH-1:0] step_h,
                           input logic [CONST_WIDTH-1:0] half_sq);
    write_setting(CFG_DAMPING, damping);
    write_setting(CFG_STIFFNESS, stiffness);
    write_setting(CFG_SHAFT_GAIN, shaft_gain);
    write_setting(CFG_CURRENT_GAIN, current_gain);
    write_setting(CFG_RATE_GAIN, rate_gain);
    write_setting(CFG_STEP_H, step_h);
    write_setting(CFG_HALF_STEP_SQ, half_sq);
  endtask

  task automatic queue_step(input logic signed [IO_WIDTH-1:0] d,
                            input logic signed [IO_WIDTH-1:0] dr);
    step_item_t it;
    it.drive      = d;
    it.drive_rate = dr;
    pending_steps.push_back(it);
  endtask

  // Every item yields a result, so once all results are in the block is idle;
  // a short extra wait covers the output handshake settling.
  task automatic wait_idle();
    while (pending_steps.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    step_ch.valid      = 1'b0;
    step_ch.drive      = '0;
    step_ch.drive_rate = '0;
    result_ch.ready    = 1'b0;

    // Reset leaves the state at zero and the nominal coefficients loaded.
    k_damping      = NOM_DAMPING;
    k_stiffness    = NOM_STIFFNESS;
    k_shaft_gain   = NOM_SHAFT;
    k_current_gain = NOM_CURRENT;
    k_rate_gain    = NOM_RATE;
    k_step         = NOM_STEP;
    k_half_sq      = NOM_HALF_SQ;
    shaft_y  = '0;
    shaft_dy = '0;
    curr_y   = '0;
    curr_dy  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Directed items with the reset coefficients: zero, extremes of both fields,
    // values of one LSB and alternating bit patterns.
    queue_step('0, '0);
    queue_step(DRIVE_MAX, '0);
    queue_step(DRIVE_MAX, DRIVE_MAX);
    queue_step(DRIVE_MIN, DRIVE_MIN);
    queue_step(DRIVE_MIN, DRIVE_MAX);
    queue_step(-48'sd1, 48'sd1);
    queue_step(48'sd1, -48'sd1);
    queue_step('0, DRIVE_MAX);
    queue_step(48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA);
    wait_idle();

    // Largest coefficients and step constants: the second derivative and the
    // states run into saturation, first positive, then negative.
    write_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, '1, '1);
    repeat (3) queue_step(DRIVE_MAX, DRIVE_MAX);
    repeat (3) queue_step(DRIVE_MIN, DRIVE_MIN);
    wait_idle();

    // Most negative coefficients with an inconsistent pair of step constants,
    // and a write past the last register that must change nothing.
    write_all(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, '1, '0);
    write_setting(CFG_SPARE, $urandom);
    queue_step(DRIVE_MAX, DRIVE_MIN);
    queue_step(DRIVE_MIN, DRIVE_MAX);
    queue_step(DRIVE_MIN, DRIVE_MAX);
    queue_step('0, '0);
    wait_idle();

    // Random part: eight settings, each with a fresh set of coefficients.
    for (int p = 0; p < 8; p++) begin
      write_all(pick_coef(NOM_DAMPING), pick_coef(NOM_STIFFNESS), pick_coef(NOM_SHAFT),
                pick_coef(NOM_CURRENT), pick_coef(NOM_RATE), pick_step(NOM_STEP),
                pick_step(NOM_HALF_SQ));
      if ($urandom_range(0, 3) == 0) begin
        write_setting(CFG_SPARE, $urandom);
      end
      for (int n = 0; n < 125; n++) begin
        queue_step(pick_drive(), pick_drive());
      end
      wait_idle();
    end

    // Back to the nominal motor for a last stretch, so the run ends on the
    // defaults again.
    write_all(NOM_DAMPING, NOM_STIFFNESS, NOM_SHAFT, NOM_CURRENT, NOM_RATE,
              NOM_STEP, NOM_HALF_SQ);
    for (int n = 0; n < 20; n++) begin
      queue_step(pick_drive(), pick_drive());
    end
    wait_idle();
    repeat (40) @(posedge clk);

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued items in bursts with random gaps. Once valid is up it
  // stays up with the same item until the block takes it. Each accepted item is
  // run through the predictor at the same edge.
  // ---------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  step_item_t taken;

  always @(posedge clk) begin
    if (rst) begin
      step_ch.valid <= 1'b0;
    end else if (!(step_ch.valid && !step_ch.ready)) begin
      if (step_ch.valid) begin
        taken = pending_steps.pop_front();
        step_channel(shaft_y, shaft_dy, k_shaft_gain, '0, taken.drive, taken.drive_rate);
        step_channel(curr_y, curr_dy, k_current_gain, k_rate_gain,
                     taken.drive, taken.drive_rate);
        expected_results.push_back('{shaft: shaft_y, current: curr_y});
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          // Long gaps reach across a whole item's computation so that the next
          // offer lands on every phase of the block's work.
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(1, 5);
            2:       gap_left = $urandom_range(1, 60);
            default: gap_left = $urandom_range(1, 450);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        step_ch.valid <= 1'b0;
      end else if (pending_steps.size() > (step_ch.valid ? 1 : 0) || !step_ch.valid
                   && pending_steps.size() > 0) begin
        step_ch.valid      <= 1'b1;
        step_ch.drive      <= pending_steps[0].drive;
        step_ch.drive_rate <= pending_steps[0].drive_rate;
      end else begin
        step_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows windows that are open, shut or choppy, of random
  // length. Twice in the run it holds off for a long stretch so that the output
  // register fills and the block stops taking input items.
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode   = RX_OPEN;
  int          rx_left   = 0;
  int unsigned rx_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 30000 || rx_cycles == 250000) begin
        rx_mode = RX_SHUT;
        rx_left = 3000;
      end else if (rx_left <= 0) begin
        case ($urandom_range(0, 2))
          0: begin
            rx_mode = RX_OPEN;
            rx_left = $urandom_range(1, 900);
          end
          1: begin
            rx_mode = RX_SHUT;
            rx_left = $urandom_range(1, 600);
          end
          default: begin
            rx_mode = RX_CHOPPY;
            rx_left = $urandom_range(1, 300);
          end
        endcase
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  result_ch.ready <= 1'b1;
        RX_SHUT:  result_ch.ready <= 1'b0;
        default:  result_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result item taken is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  motor_result_t want;

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= NOISY_LIMIT) begin
          $display("result item with none expected: shaft %h current %h",
                   result_ch.shaft_out, result_ch.current_out);
        end
      end else begin
        want = expected_results.pop_front();
        if (result_ch.shaft_out !== want.shaft || result_ch.current_out !== want.current) begin
          fault_count++;
          if (fault_count <= NOISY_LIMIT) begin
            $display("mismatch: shaft exp %h got %h, current exp %h got %h",
                     want.shaft, result_ch.shaft_out, want.current, result_ch.current_out);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
design/dcmi_pkg.sv
design/dcmi_if.sv
design/dcmi_mac.sv
design/dcmi_seq.sv
design/dc_motor_model_integrator.sv
dv/testbench.sv
